// ===== rtl/det_pkg.sv =====
// ----------------------------------------------------------------------------
// det_pkg: shared types and constants of the digit-entry time setter
// Command codes, entry phases, reply codes and the record of one result.
// ----------------------------------------------------------------------------
package det_pkg;

	localparam int TIMEOUT_W      = 16;
	localparam int TICK_WIDTH_DEF = 16;
	localparam int ENTRY_DIGITS   = 4;
	localparam int DIGIT_IDX_W    = $clog2(ENTRY_DIGITS);

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd8000;

	localparam logic [7:0] HOUR_LIMIT  = 8'd24;
	localparam logic [7:0] MINUTE_LIMIT = 8'd60;
	localparam logic [7:0] CDOWN_MAX   = 8'd99;

	localparam logic [2:0] CMD_TICK        = 3'd0;
	localparam logic [2:0] CMD_START_ALARM = 3'd1;
	localparam logic [2:0] CMD_START_CDOWN = 3'd2;
	localparam logic [2:0] CMD_DIGIT       = 3'd3;
	localparam logic [2:0] CMD_ABORT       = 3'd4;

	localparam logic [2:0] RC_NONE     = 3'd0;
	localparam logic [2:0] RC_SLOT_OK  = 3'd1;
	localparam logic [2:0] RC_SLOT_BAD = 3'd2;
	localparam logic [2:0] RC_ALARM_OK = 3'd3;
	localparam logic [2:0] RC_ALARM_BAD = 3'd4;
	localparam logic [2:0] RC_CDOWN_OK = 3'd5;
	localparam logic [2:0] RC_CDOWN_BAD = 3'd6;
	localparam logic [2:0] RC_TIMEOUT  = 3'd7;

	localparam logic [1:0] MODE_KEEP       = 2'd0;
	localparam logic [1:0] MODE_SHOW_ALARM = 2'd1;
	localparam logic [1:0] MODE_CDOWN      = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_SLOT  = 2'd1,
		PH_ALARM = 2'd2,
		PH_CDOWN = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] count;
		logic [1:0] slot;
	} entry_t;

	typedef struct packed {
		logic        beep;
		logic [2:0]  reply_code;
		logic [7:0]  reply_first;
		logic [5:0]  reply_second;
		logic [1:0]  mode_select;
		logic        alarm_write;
		logic [1:0]  alarm_slot;
		logic [4:0]  alarm_hour;
		logic [5:0]  alarm_minute;
		logic        countdown_write;
		logic [12:0] countdown_seconds;
		logic        busy_res;
	} result_t;

endpackage

// ===== rtl/det_step.sv =====
// ----------------------------------------------------------------------------
// det_step: decode of one command
// Computes the next entry state and the result record from the current state.
// ----------------------------------------------------------------------------
module det_step #(
	parameter int TICK_WIDTH = det_pkg::TICK_WIDTH_DEF
) (
	input  logic [2:0]                     cmd,
	input  logic [3:0]                     digit,
	input  det_pkg::entry_t                cur,
	input  logic [TICK_WIDTH-1:0]          quiet,
	input  logic [det_pkg::TIMEOUT_W-1:0]  timeout,
	input  logic [3:0]                     store0,
	input  logic [3:0]                     store1,
	input  logic [3:0]                     store2,
	output det_pkg::entry_t                nxt,
	output logic [TICK_WIDTH-1:0]          quiet_nxt,
	output logic                           store_we,
	output det_pkg::result_t               res
);
	import det_pkg::*;

	localparam int CMP_W = (TICK_WIDTH > TIMEOUT_W) ? TICK_WIDTH : TIMEOUT_W;

	logic [TICK_WIDTH-1:0] quiet_inc;
	logic                  timeout_hit;
	logic [2:0]            new_count;
	logic                  eval_alarm;
	logic                  eval_cdown;
	logic                  slot_ok;
	logic [7:0]            hh;
	logic [7:0]            mm_a;
	logic [7:0]            mm_c;
	logic                  alarm_ok;
	logic                  cdown_ok;

	assign quiet_inc   = (quiet == '1) ? quiet : quiet + 1'b1;
	assign timeout_hit = CMP_W'(quiet_inc) > CMP_W'(timeout);
	assign new_count   = cur.count + 3'd1;
	assign eval_alarm  = (cur.phase == PH_ALARM) && (new_count == 3'd4);
	assign eval_cdown  = (cur.phase == PH_CDOWN) && (new_count == 3'd2);
	assign slot_ok     = (digit >= 4'd1) && (digit <= 4'd3);
	assign hh          = 8'(store0) * 8'd10 + 8'(store1);
	assign mm_a        = 8'(store2) * 8'd10 + 8'(digit);
	assign mm_c        = 8'(store0) * 8'd10 + 8'(digit);
	assign alarm_ok    = (hh < HOUR_LIMIT) && (mm_a < MINUTE_LIMIT);
	assign cdown_ok    = (mm_c != 8'd0) && (mm_c <= CDOWN_MAX);

	always_comb begin
		nxt       = cur;
		quiet_nxt = quiet;
		store_we  = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (cur.phase != PH_IDLE) begin
					quiet_nxt = quiet_inc;
					if (timeout_hit) begin
						nxt.phase = PH_IDLE;
						nxt.count = 3'd0;
						quiet_nxt = '0;
					end
				end
			end
			CMD_START_ALARM: begin
				nxt.phase = PH_SLOT;
				quiet_nxt = '0;
			end
			CMD_START_CDOWN: begin
				nxt.phase = PH_CDOWN;
				nxt.count = 3'd0;
				quiet_nxt = '0;
			end
			CMD_DIGIT: begin
				if (cur.phase != PH_IDLE) begin
					quiet_nxt = '0;
					if (cur.phase == PH_SLOT) begin
						if (slot_ok) begin
							nxt.slot  = 2'(digit - 4'd1);
							nxt.phase = PH_ALARM;
							nxt.count = 3'd0;
						end
					end else begin
						store_we  = 1'b1;
						nxt.count = new_count;
						if (eval_alarm || eval_cdown) begin
							nxt.phase = PH_IDLE;
							nxt.count = 3'd0;
						end
					end
				end
			end
			CMD_ABORT: begin
				nxt.phase = PH_IDLE;
				nxt.count = 3'd0;
				quiet_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res = '0;
		case (cmd)
			CMD_TICK: begin
				if ((cur.phase != PH_IDLE) && timeout_hit) begin
					res.reply_code = RC_TIMEOUT;
				end
			end
			CMD_START_CDOWN: begin
				res.mode_select = MODE_CDOWN;
			end
			CMD_DIGIT: begin
				if (cur.phase != PH_IDLE) begin
					res.beep = 1'b1;
					if (cur.phase == PH_SLOT) begin
						if (slot_ok) begin
							res.reply_code  = RC_SLOT_OK;
							res.reply_first = 8'(digit);
							res.mode_select = MODE_SHOW_ALARM;
						end else begin
							res.reply_code = RC_SLOT_BAD;
						end
					end else if (eval_alarm) begin
						if (alarm_ok) begin
							res.reply_code   = RC_ALARM_OK;
							res.reply_first  = hh;
							res.reply_second = 6'(mm_a);
							res.mode_select  = MODE_SHOW_ALARM;
							res.alarm_write  = 1'b1;
							res.alarm_slot   = cur.slot;
							res.alarm_hour   = 5'(hh);
							res.alarm_minute = 6'(mm_a);
						end else begin
							res.reply_code = RC_ALARM_BAD;
						end
					end else if (eval_cdown) begin
						if (cdown_ok) begin
							res.reply_code        = RC_CDOWN_OK;
							res.reply_first       = mm_c;
							res.mode_select       = MODE_CDOWN;
							res.countdown_write   = 1'b1;
							res.countdown_seconds = 13'(mm_c) * 13'd60;
						end else begin
							res.reply_code = RC_CDOWN_BAD;
						end
					end
				end
			end
			default: begin
			end
		endcase
		res.busy_res = (nxt.phase != PH_IDLE);
	end

endmodule

// ===== rtl/digit_entry_time_setter.sv =====
// ----------------------------------------------------------------------------
// digit_entry_time_setter: digit-entry controller for alarm and countdown
// Takes tick, start, digit and abort commands and gives one reply for each.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata bits (lowest first)
//  s_axis   | in        | cmd[2:0], digit[6:3], zero pad [7]
//  m_axis   | out       | 49 result bits, zero pad [55:49]
//  cfg      | in        | timeout_ticks[15:0]
//
// Every command gives exactly one result, registered as it leaves the input
// register; a new command can be taken in every cycle unless the output stalls.
// The command is decoded between the input register and the result register.
// Reset clears the entry state and loads timeout_ticks with 8000.
// A stalled result is held while the input register still takes one command.
// ----------------------------------------------------------------------------
module digit_entry_time_setter #(
	parameter int TICK_WIDTH = det_pkg::TICK_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // cmd[2:0], digit[6:3]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// beep[0], reply_code[3:1], reply_first[11:4], reply_second[17:12],
	// mode_select[19:18], alarm_write[20], alarm_slot[22:21],
	// alarm_hour[27:23], alarm_minute[33:28], countdown_write[34],
	// countdown_seconds[47:35], busy_res[48]
	output logic [55:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [det_pkg::TIMEOUT_W-1:0] cfg_data
);
	import det_pkg::*;

	logic [TIMEOUT_W-1:0]  timeout_q;
	logic                  s1_valid_q;
	logic [2:0]            cmd_s1;
	logic [3:0]            digit_s1;
	entry_t                entry_q;
	entry_t                entry_nxt;
	logic [TICK_WIDTH-1:0] quiet_q;
	logic [TICK_WIDTH-1:0] quiet_nxt;
	logic [3:0]            store_q [ENTRY_DIGITS];
	logic                  store_we;
	result_t               res;
	result_t               res_q;
	logic                  out_valid_q;
	logic                  advance;
	logic                  accept;

	assign cfg_ready     = 1'b1;
	assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;

	det_step #(
		.TICK_WIDTH(TICK_WIDTH)
	) u_step (
		.cmd      (cmd_s1),
		.digit    (digit_s1),
		.cur      (entry_q),
		.quiet    (quiet_q),
		.timeout  (timeout_q),
		.store0   (store_q[0]),
		.store1   (store_q[1]),
		.store2   (store_q[2]),
		.nxt      (entry_nxt),
		.quiet_nxt(quiet_nxt),
		.store_we (store_we),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= s_axis_tdata[2:0];
			digit_s1 <= s_axis_tdata[6:3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '{phase: PH_IDLE, count: 3'd0, slot: 2'd0};
			quiet_q <= '0;
		end else if (advance) begin
			entry_q <= entry_nxt;
			quiet_q <= quiet_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && store_we) begin
			store_q[entry_q.count[DIGIT_IDX_W-1:0]] <= digit_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tdata = {
		7'd0,
		res_q.busy_res,
		res_q.countdown_seconds,
		res_q.countdown_write,
		res_q.alarm_minute,
		res_q.alarm_hour,
		res_q.alarm_slot,
		res_q.alarm_write,
		res_q.mode_select,
		res_q.reply_second,
		res_q.reply_first,
		res_q.reply_code,
		res_q.beep
	};

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		entry_q.phase == PH_IDLE |-> quiet_q == '0)
		else $error("quiet counter runs while no entry is open");

	a_result_moves: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_valid_q |=> out_valid_q)
		else $error("command in input register did not reach the output");

	a_alarm_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.alarm_write |-> res_q.reply_code == RC_ALARM_OK
			&& !res_q.busy_res)
		else $error("alarm write without alarm set reply");

	a_cdown_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.countdown_write |-> res_q.countdown_seconds != 13'd0
			&& res_q.reply_code == RC_CDOWN_OK)
		else $error("countdown write with empty length");

endmodule
